// ----- rtl/core/qslerp_pkg.sv -----
package qslerp_pkg;

    localparam int FRAC_BITS        = 14;
    localparam int ONE              = 1 << FRAC_BITS;
    localparam int ANG_BITS         = 30;
    localparam int UP_SHIFT         = ANG_BITS - FRAC_BITS;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int COMP_W           = 16;
    localparam int FRAC_W           = FRAC_BITS + 1;
    localparam int CW               = 34;
    localparam int SQ_W             = 2 * FRAC_BITS + 2;
    localparam int SQ_STEPS         = FRAC_BITS + 1;
    localparam int DIV_STEPS        = FRAC_BITS + 1;
    localparam int REM_W            = 34;
    localparam int DEN_W            = 31;

    localparam logic [FRAC_W-1:0] NEAR_RESET = FRAC_W'(16382);
    localparam logic [FRAC_W-1:0] ONE_F      = FRAC_W'(ONE);

    typedef logic signed [CW-1:0] t_cw;
    typedef logic [SQ_W-1:0]      t_sq;
    typedef logic [REM_W-1:0]     t_rem;
    typedef logic [DEN_W-1:0]     t_den;
    typedef logic [DIV_STEPS-1:0] t_quo;

    localparam logic [31:0] ATAN_Q30 [32] = '{
        32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159, 32'd67021687,
        32'd33543516, 32'd16775851, 32'd8388437, 32'd4194283, 32'd2097149,
        32'd1048576, 32'd524288, 32'd262144, 32'd131072, 32'd65536, 32'd32768,
        32'd16384, 32'd8192, 32'd4096, 32'd2048, 32'd1024, 32'd512, 32'd256,
        32'd128, 32'd64, 32'd32, 32'd16, 32'd8, 32'd4, 32'd2, 32'd1, 32'd0
    };

endpackage

// ----- rtl/core/qslerp_sqrt_cell.sv -----
module qslerp_sqrt_cell #(
    parameter int POS = 0
) (
    input  logic            i_clk,
    input  logic            i_en,
    input  qslerp_pkg::t_sq i_v,
    input  qslerp_pkg::t_sq i_res,
    output qslerp_pkg::t_sq o_v,
    output qslerp_pkg::t_sq o_res
);
    import qslerp_pkg::*;

    localparam t_sq BIT_VAL = t_sq'(1) << (2 * POS);

    t_sq trial;
    t_sq r_v;
    t_sq r_res;
    t_sq n_v;
    t_sq n_res;

    always_comb begin
        trial = i_res + BIT_VAL;
        if (i_v >= trial) begin
            n_v   = i_v - trial;
            n_res = (i_res >> 1) + BIT_VAL;
        end else begin
            n_v   = i_v;
            n_res = i_res >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_v   <= n_v;
            r_res <= n_res;
        end
    end

    assign o_v   = r_v;
    assign o_res = r_res;

endmodule

// ----- rtl/core/qslerp_cordic_cell.sv -----
module qslerp_cordic_cell #(
    parameter int STEP   = 0,
    parameter bit VECTOR = 1'b0
) (
    input  logic            i_clk,
    input  logic            i_en,
    input  qslerp_pkg::t_cw i_x,
    input  qslerp_pkg::t_cw i_y,
    input  qslerp_pkg::t_cw i_z,
    output qslerp_pkg::t_cw o_x,
    output qslerp_pkg::t_cw o_y,
    output qslerp_pkg::t_cw o_z
);
    import qslerp_pkg::*;

    localparam t_cw ANG = $signed({2'b00, ATAN_Q30[STEP]});

    logic cw;
    t_cw  xs;
    t_cw  ys;
    t_cw  r_x;
    t_cw  r_y;
    t_cw  r_z;

    assign cw = VECTOR ? (i_y > 0) : (i_z < 0);
    assign xs = i_x >>> STEP;
    assign ys = i_y >>> STEP;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (cw) begin
                r_x <= i_x + ys;
                r_y <= i_y - xs;
                r_z <= i_z + ANG;
            end else begin
                r_x <= i_x - ys;
                r_y <= i_y + xs;
                r_z <= i_z - ANG;
            end
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;

endmodule

// ----- rtl/core/qslerp_div_cell.sv -----
module qslerp_div_cell #(
    parameter int QBIT = 0
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  qslerp_pkg::t_rem i_rem,
    input  qslerp_pkg::t_den i_den,
    input  qslerp_pkg::t_quo i_q,
    output qslerp_pkg::t_rem o_rem,
    output qslerp_pkg::t_den o_den,
    output qslerp_pkg::t_quo o_q
);
    import qslerp_pkg::*;

    t_rem den_ext;
    t_rem rem_sub;
    logic ge;
    t_quo n_q;
    t_rem r_rem;
    t_den r_den;
    t_quo r_q;

    always_comb begin
        den_ext = REM_W'(i_den);
        ge      = (i_rem >= den_ext);
        rem_sub = ge ? (i_rem - den_ext) : i_rem;
        n_q       = i_q;
        n_q[QBIT] = ge;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= {rem_sub[REM_W-2:0], 1'b0};
            r_den <= i_den;
            r_q   <= n_q;
        end
    end

    assign o_rem = r_rem;
    assign o_den = r_den;
    assign o_q   = r_q;

endmodule

// ----- rtl/core/quaternion_slerp_interpolator.sv -----
// Fixed-point quaternion slerp, one result beat per input beat, fully pipelined: a new
// quaternion pair and fraction can be taken every cycle while the output beat is taken or
// no output beat is valid. The pipeline is a chain of cells: 15 square-root cells,
// CORDIC_STEPS vectoring cells for the arc angle, three rotation chains of CORDIC_STEPS
// cells in parallel for the sines, and two 15-cell dividers for the weights, plus dot
// product, multiply and rounding stages.
// The whole pipeline holds when the output beat is not taken. Components are signed Q2.14,
// the fraction is unsigned Q1.14 (clamped to one), and the outputs are rounded and saturated.
// near_threshold may be written any time the block is idle.
module quaternion_slerp_interpolator #(
    parameter int CORDIC_STEPS = qslerp_pkg::CORDIC_STEPS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_wr_en,
    input  logic [14:0]  i_cfg_wr_data,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // start_w, start_x, start_y, start_z, end_w, end_x, end_y, end_z, fraction, pad
    input  logic [143:0] i_s_axis_tdata,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // blend_w, blend_x, blend_y, blend_z
    output logic [63:0]  o_m_axis_tdata
);
    import qslerp_pkg::*;

    localparam int SQ_END   = 2 + SQ_STEPS;
    localparam int VEC_END  = SQ_END + CORDIC_STEPS;
    localparam int MUL      = VEC_END + 1;
    localparam int ROT_END  = MUL + CORDIC_STEPS;
    localparam int PREP     = ROT_END + 1;
    localparam int DIV_END  = PREP + DIV_STEPS;
    localparam int WGT      = DIV_END + 1;
    localparam int PRD      = WGT + 1;
    localparam int OUTS     = PRD + 1;

    typedef struct packed {
        logic [3:0][15:0]  a;
        logic [3:0][15:0]  b;
        logic [FRAC_W-1:0] t;
        logic [FRAC_W-1:0] cc;
        logic              neg;
        logic              near;
        logic              den_pos;
        logic              zero0;
        logic              zero1;
        logic              sat0;
        logic              sat1;
    } t_side;

    logic              en;
    logic [OUTS:0]     r_vld;
    t_side             r_side [PRD+1];
    t_side             in_side;
    t_side             n_side_cos;
    t_side             n_side_prep;
    logic [FRAC_W-1:0] r_near_thr;

    logic signed [31:0] r_prod [4];
    logic signed [33:0] d2;
    logic [33:0]        dabs;
    logic [19:0]        cval;
    logic [SQ_W-1:0]    r_cc2;

    t_sq sq_v [SQ_STEPS+1];
    t_sq sq_r [SQ_STEPS+1];

    t_cw vx [CORDIC_STEPS+1];
    t_cw vy [CORDIC_STEPS+1];
    t_cw vz [CORDIC_STEPS+1];

    t_cw r_om;
    t_cw r_a0;
    t_cw r_a1;
    logic signed [48:0] ang0;
    logic signed [48:0] ang1;

    t_cw rx [3][CORDIC_STEPS+1];
    t_cw ry [3][CORDIC_STEPS+1];
    t_cw rz [3][CORDIC_STEPS+1];

    t_rem dv_rem [2][DIV_STEPS+1];
    t_den dv_den [2][DIV_STEPS+1];
    t_quo dv_q   [2][DIV_STEPS+1];

    t_cw  den;
    t_cw  num0;
    t_cw  num1;
    t_rem r_rem0;
    t_rem r_rem1;
    t_den r_den;

    logic [FRAC_W-1:0] r_k0;
    logic [FRAC_W-1:0] r_k1;
    logic [FRAC_W-1:0] k0_sl;
    logic [FRAC_W-1:0] k1_sl;
    logic              lin;

    logic signed [33:0] r_p0 [4];
    logic signed [33:0] r_p1 [4];
    logic [63:0]        r_out;
    logic [63:0]        n_out;

    function automatic logic [FRAC_W-1:0] weight_sel(
        input t_quo q,
        input logic zero,
        input logic sat
    );
        logic [FRAC_W-1:0] k;
        begin
            if (zero) begin
                k = '0;
            end else if (sat || (FRAC_W'(q) > ONE_F)) begin
                k = ONE_F;
            end else begin
                k = FRAC_W'(q);
            end
            return k;
        end
    endfunction

    assign en              = !r_vld[OUTS] || i_m_axis_tready;
    assign o_s_axis_tready = en;
    assign o_m_axis_tvalid = r_vld[OUTS];
    assign o_m_axis_tdata  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_near_thr <= NEAR_RESET;
        end else if (i_cfg_wr_en) begin
            r_near_thr <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[OUTS-1:0], i_s_axis_tvalid};
        end
    end

    always_comb begin
        in_side = '0;
        for (int j = 0; j < 4; j++) begin
            in_side.a[j] = i_s_axis_tdata[16*j +: 16];
            in_side.b[j] = i_s_axis_tdata[64 + 16*j +: 16];
        end
        in_side.t = (i_s_axis_tdata[142:128] > ONE_F) ? ONE_F : i_s_axis_tdata[142:128];
    end

    always_comb begin
        d2 = '0;
        for (int j = 0; j < 4; j++) begin
            d2 = d2 + 34'(r_prod[j]);
        end
        dabs = (d2 < 0) ? 34'(-d2) : 34'(d2);
        cval = 20'((dabs + 34'(ONE / 2)) >> FRAC_BITS);
    end

    always_comb begin
        n_side_cos      = r_side[0];
        n_side_cos.neg  = d2 < 0;
        n_side_cos.near = cval > 20'(r_near_thr);
        n_side_cos.cc   = (cval > 20'(ONE)) ? ONE_F : cval[FRAC_W-1:0];

        n_side_prep         = r_side[PREP-1];
        n_side_prep.den_pos = den > 0;
        n_side_prep.zero0   = num0 <= 0;
        n_side_prep.zero1   = num1 <= 0;
        n_side_prep.sat0    = $signed({num0[CW-1], num0}) >= $signed({den, 1'b0});
        n_side_prep.sat1    = $signed({num1[CW-1], num1}) >= $signed({den, 1'b0});
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side[0] <= in_side;
            for (int j = 0; j < 4; j++) begin
                r_prod[j] <= $signed(i_s_axis_tdata[16*j +: 16])
                           * $signed(i_s_axis_tdata[64 + 16*j +: 16]);
            end
            for (int k = 1; k <= PRD; k++) begin
                if (k == 1) begin
                    r_side[k] <= n_side_cos;
                end else if (k == PREP) begin
                    r_side[k] <= n_side_prep;
                end else begin
                    r_side[k] <= r_side[k-1];
                end
            end
            r_cc2 <= SQ_W'(r_side[1].cc) * SQ_W'(r_side[1].cc);

            r_om <= vz[CORDIC_STEPS];
            r_a0 <= CW'(ang0 >>> FRAC_BITS);
            r_a1 <= CW'(ang1 >>> FRAC_BITS);

            r_rem0 <= REM_W'(num0);
            r_rem1 <= REM_W'(num1);
            r_den  <= den[DEN_W-1:0];

            r_k0 <= lin ? (ONE_F - r_side[DIV_END].t) : k0_sl;
            r_k1 <= lin ? r_side[DIV_END].t : k1_sl;

            for (int j = 0; j < 4; j++) begin
                r_p0[j] <= 34'((r_side[WGT].neg ? -17'($signed(r_side[WGT].a[j]))
                                                : 17'($signed(r_side[WGT].a[j])))
                               * $signed({2'b00, r_k0}));
                r_p1[j] <= 34'($signed(r_side[WGT].b[j]) * $signed({1'b0, r_k1}));
            end

            r_out <= n_out;
        end
    end

    assign ang0 = $signed({1'b0, ONE_F - r_side[VEC_END].t}) * $signed(vz[CORDIC_STEPS]);
    assign ang1 = $signed({1'b0, r_side[VEC_END].t}) * $signed(vz[CORDIC_STEPS]);

    assign sq_v[0] = SQ_W'(ONE) * SQ_W'(ONE) - r_cc2;
    assign sq_r[0] = '0;

    for (genvar i = 0; i < SQ_STEPS; i++) begin : g_sqrt
        qslerp_sqrt_cell #(
            .POS(SQ_STEPS - 1 - i)
        ) u_cell (
            .i_clk (i_clk),
            .i_en  (en),
            .i_v   (sq_v[i]),
            .i_res (sq_r[i]),
            .o_v   (sq_v[i+1]),
            .o_res (sq_r[i+1])
        );
    end

    assign vx[0] = CW'(r_side[SQ_END].cc) <<< UP_SHIFT;
    assign vy[0] = CW'(sq_r[SQ_STEPS]) <<< UP_SHIFT;
    assign vz[0] = '0;

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_vec
        qslerp_cordic_cell #(
            .STEP   (i),
            .VECTOR (1'b1)
        ) u_cell (
            .i_clk (i_clk),
            .i_en  (en),
            .i_x   (vx[i]),
            .i_y   (vy[i]),
            .i_z   (vz[i]),
            .o_x   (vx[i+1]),
            .o_y   (vy[i+1]),
            .o_z   (vz[i+1])
        );
    end

    for (genvar c = 0; c < 3; c++) begin : g_rot
        assign rx[c][0] = CW'(1) <<< ANG_BITS;
        assign ry[c][0] = '0;
        assign rz[c][0] = (c == 0) ? r_om : ((c == 1) ? r_a0 : r_a1);
        for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
            qslerp_cordic_cell #(
                .STEP   (i),
                .VECTOR (1'b0)
            ) u_cell (
                .i_clk (i_clk),
                .i_en  (en),
                .i_x   (rx[c][i]),
                .i_y   (ry[c][i]),
                .i_z   (rz[c][i]),
                .o_x   (rx[c][i+1]),
                .o_y   (ry[c][i+1]),
                .o_z   (rz[c][i+1])
            );
        end
    end

    assign den  = ry[0][CORDIC_STEPS];
    assign num0 = ry[1][CORDIC_STEPS];
    assign num1 = ry[2][CORDIC_STEPS];

    for (genvar c = 0; c < 2; c++) begin : g_div
        assign dv_rem[c][0] = (c == 0) ? r_rem0 : r_rem1;
        assign dv_den[c][0] = r_den;
        assign dv_q[c][0]   = '0;
        for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
            qslerp_div_cell #(
                .QBIT(DIV_STEPS - 1 - i)
            ) u_cell (
                .i_clk (i_clk),
                .i_en  (en),
                .i_rem (dv_rem[c][i]),
                .i_den (dv_den[c][i]),
                .i_q   (dv_q[c][i]),
                .o_rem (dv_rem[c][i+1]),
                .o_den (dv_den[c][i+1]),
                .o_q   (dv_q[c][i+1])
            );
        end
    end

    assign lin   = r_side[DIV_END].near || !r_side[DIV_END].den_pos;
    assign k0_sl = weight_sel(dv_q[0][DIV_STEPS], r_side[DIV_END].zero0, r_side[DIV_END].sat0);
    assign k1_sl = weight_sel(dv_q[1][DIV_STEPS], r_side[DIV_END].zero1, r_side[DIV_END].sat1);

    always_comb begin
        logic signed [33:0] v;
        logic signed [33:0] rv;
        n_out = '0;
        for (int j = 0; j < 4; j++) begin
            v  = r_p0[j] + r_p1[j];
            rv = (v + 34'sd8192) >>> FRAC_BITS;
            if (rv > 34'sd32767) begin
                n_out[16*j +: 16] = 16'h7FFF;
            end else if (rv < -34'sd32768) begin
                n_out[16*j +: 16] = 16'h8000;
            end else begin
                n_out[16*j +: 16] = rv[15:0];
            end
        end
    end

endmodule

// ----- verif/quaternion_slerp_checker.sv -----
module quaternion_slerp_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_wr_en,
    input  logic [14:0]  i_cfg_wr_data,
    input  logic         i_in_valid,
    input  logic         i_in_ready,
    input  logic [143:0] i_in_data,
    input  logic         i_out_valid,
    input  logic         i_out_ready,
    input  logic [63:0]  i_out_data,
    output int           o_errors,
    output int           o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import qslerp_pkg::*;

    logic [14:0] threshold;
    logic [63:0] blend_queue[$];

    function automatic longint floor_shr(longint v, int n);
        return v >>> n;
    endfunction

    function automatic longint round_shr(longint v, int n);
        return (v + (longint'(1) << (n - 1))) >>> n;
    endfunction

    function automatic longint int_sqrt(longint v);
        longint res;
        longint bit_val;
        res = 0;
        bit_val = longint'(1) << 62;
        while (bit_val > v) bit_val = bit_val >> 2;
        while (bit_val != 0) begin
            if (v >= res + bit_val) begin
                v = v - (res + bit_val);
                res = (res >> 1) + bit_val;
            end else begin
                res = res >> 1;
            end
            bit_val = bit_val >> 2;
        end
        return res;
    endfunction

    function automatic longint arc_angle(longint x, longint y);
        longint z;
        longint nx;
        z = 0;
        for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
            if (y > 0) begin
                nx = x + floor_shr(y, i);
                y = y - floor_shr(x, i);
                z = z + longint'(ATAN_Q30[i]);
            end else begin
                nx = x - floor_shr(y, i);
                y = y + floor_shr(x, i);
                z = z - longint'(ATAN_Q30[i]);
            end
            x = nx;
        end
        return z;
    endfunction

    function automatic longint scaled_sine(longint z);
        longint x;
        longint y;
        longint nx;
        x = longint'(1) << ANG_BITS;
        y = 0;
        for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
            if (z >= 0) begin
                nx = x - floor_shr(y, i);
                y = y + floor_shr(x, i);
                z = z - longint'(ATAN_Q30[i]);
            end else begin
                nx = x + floor_shr(y, i);
                y = y - floor_shr(x, i);
                z = z + longint'(ATAN_Q30[i]);
            end
            x = nx;
        end
        return y;
    endfunction

    function automatic longint sine_ratio(longint num, longint den);
        longint k;
        if (num <= 0) return 0;
        k = (num * ONE) / den;
        return (k > ONE) ? ONE : k;
    endfunction

    function automatic logic [63:0] slerp_blend(logic [143:0] d, logic [14:0] thr);
        longint qa[4];
        longint qb[4];
        longint dot;
        longint frac;
        longint cosv;
        longint cc;
        longint sinv;
        longint omega;
        longint den;
        longint k0;
        longint k1;
        longint v;
        logic [63:0] res;
        dot = 0;
        for (int j = 0; j < 4; j++) begin
            qa[j] = longint'($signed(d[16*j +: 16]));
            qb[j] = longint'($signed(d[64 + 16*j +: 16]));
            dot = dot + qa[j] * qb[j];
        end
        frac = longint'(d[128 +: 15]);
        if (frac > ONE) frac = ONE;
        if (dot < 0) begin
            for (int j = 0; j < 4; j++) qa[j] = -qa[j];
            dot = -dot;
        end
        cosv = round_shr(dot, FRAC_BITS);
        k0 = ONE - frac;
        k1 = frac;
        if (cosv <= longint'(thr)) begin
            cc = (cosv > ONE) ? ONE : cosv;
            sinv = int_sqrt(longint'(ONE) * ONE - cc * cc);
            omega = arc_angle(cc << UP_SHIFT, sinv << UP_SHIFT);
            den = scaled_sine(omega);
            if (den > 0) begin
                k0 = sine_ratio(scaled_sine(floor_shr((ONE - frac) * omega, FRAC_BITS)), den);
                k1 = sine_ratio(scaled_sine(floor_shr(frac * omega, FRAC_BITS)), den);
            end
        end
        for (int j = 0; j < 4; j++) begin
            v = round_shr(qa[j] * k0 + qb[j] * k1, FRAC_BITS);
            if (v > 32767) v = 32767;
            if (v < -32768) v = -32768;
            res[16*j +: 16] = v[15:0];
        end
        return res;
    endfunction

    assign o_pending = blend_queue.size();

    always @(posedge i_clk) begin
        logic [63:0] want;
        if (!i_rst_n) begin
            threshold <= NEAR_RESET;
            o_errors <= 0;
            blend_queue.delete();
        end else begin
            if (i_cfg_wr_en) threshold <= i_cfg_wr_data;
            if (i_in_valid && i_in_ready) blend_queue.push_back(slerp_blend(i_in_data, threshold));
            if (i_out_valid && i_out_ready) begin
                if (blend_queue.size() == 0) begin
                    if (o_errors < 10) $display("unexpected beat %h", i_out_data);
                    o_errors <= o_errors + 1;
                end else begin
                    want = blend_queue.pop_front();
                    if (want !== i_out_data) begin
                        if (o_errors < 10)
                            $display("beat mismatch: expected %h got %h", want, i_out_data);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end
endmodule

// ----- verif/quaternion_slerp_interpolator_tb.sv -----
module quaternion_slerp_interpolator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import qslerp_pkg::*;

    localparam int LATENCY = 2 * CORDIC_STEPS_DEF + 37;
    localparam int WATCHDOG = 20000;

    logic         i_clk = 0;
    logic         i_rst_n = 0;
    logic         cfg_wr_en = 0;
    logic [14:0]  cfg_wr_data = 0;
    logic         in_valid = 0;
    logic         in_ready;
    logic [143:0] in_data = 0;
    logic         out_valid;
    logic         out_ready = 0;
    logic [63:0]  out_data;
    int           errors;
    int           pending;
    int           idle_cycles = 0;
    bit           hold_off = 0;

    always #1 i_clk = ~i_clk;

    quaternion_slerp_interpolator dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_wr_en(cfg_wr_en), .i_cfg_wr_data(cfg_wr_data),
        .i_s_axis_tvalid(in_valid), .o_s_axis_tready(in_ready), .i_s_axis_tdata(in_data),
        .o_m_axis_tvalid(out_valid), .i_m_axis_tready(out_ready), .o_m_axis_tdata(out_data)
    );

    quaternion_slerp_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_wr_en(cfg_wr_en), .i_cfg_wr_data(cfg_wr_data),
        .i_in_valid(in_valid), .i_in_ready(in_ready), .i_in_data(in_data),
        .i_out_valid(out_valid), .i_out_ready(out_ready), .i_out_data(out_data),
        .o_errors(errors), .o_pending(pending)
    );

    function automatic int gap_len();
        if ($urandom_range(0, 2) == 0) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(20, 80);
        return $urandom_range(1, 3);
    endfunction

    function automatic logic [15:0] near_unit(logic [15:0] base);
        return base + 16'($signed($urandom_range(0, 64)) - 32);
    endfunction

    function automatic logic [143:0] random_pair();
        logic [143:0] d;
        logic [15:0] q[4];
        int mode;
        mode = $urandom_range(0, 9);
        d = 144'({$urandom, $urandom, $urandom, $urandom, $urandom});
        for (int j = 0; j < 4; j++) q[j] = 16'($urandom_range(0, 16384) >> $urandom_range(0, 3));
        if (mode < 4) begin
            for (int j = 0; j < 4; j++) begin
                d[16*j +: 16] = ($urandom_range(0, 1) ? -q[j] : q[j]) >> 1;
                d[64 + 16*j +: 16] = near_unit(d[16*j +: 16]);
            end
        end else if (mode < 6) begin
            for (int j = 0; j < 4; j++) begin
                d[16*j +: 16] = 16'($signed(q[j]) >>> 1);
                d[64 + 16*j +: 16] = 16'($signed($urandom_range(0, 16384)) - 8192);
            end
        end else if (mode == 6) begin
            d[0 +: 16] = 16'(ONE);
            d[16 +: 48] = 0;
            d[64 +: 16] = ($urandom_range(0, 1)) ? -16'(ONE) + 16'($urandom_range(0, 8))
                                                 : 16'(ONE) - 16'($urandom_range(0, 8));
            d[80 +: 48] = {16'($urandom_range(0, 15)), 16'($urandom_range(0, 15)),
                           16'($urandom_range(0, 15))};
        end
        if ($urandom_range(0, 3) != 0) d[128 +: 15] = 15'($urandom_range(0, ONE));
        d[143 -: 1] = 0;
        return d;
    endfunction

    task automatic send(logic [143:0] d);
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            in_valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1;
        in_data <= d;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
    endtask

    task automatic drain();
        in_valid <= 0;
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
    endtask

    task automatic write_threshold(logic [14:0] v);
        cfg_wr_en <= 1;
        cfg_wr_data <= v;
        @(posedge i_clk);
        cfg_wr_en <= 0;
        @(posedge i_clk);
    endtask

    function automatic logic [143:0] pack(logic [15:0] a[4], logic [15:0] b[4],
                                          logic [14:0] f);
        return {1'b0, f, b[3], b[2], b[1], b[0], a[3], a[2], a[1], a[0]};
    endfunction

    always @(posedge i_clk) begin
        int gap;
        if (!i_rst_n || hold_off) begin
            out_ready <= 0;
        end else begin
            gap = gap_len();
            out_ready <= (gap == 0) || ($urandom_range(0, 1) == 0);
        end
    end

    always @(posedge i_clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !i_rst_n) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG) begin
            $display("quaternion_slerp_interpolator test failed");
            $finish;
        end
    end

    initial begin
        logic [15:0] qa[4];
        logic [15:0] qb[4];
        logic [14:0] settings[5];
        settings = '{15'd16382, 15'd0, 15'd16384, 15'd32767, 15'd12000};
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        qa = '{16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000};
        qb = '{16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF};
        send(pack(qa, qb, 15'd0));
        send(pack(qa, qb, 15'h7FFF));
        send(pack(qa, qa, 15'd8192));
        qa = '{16'd16384, 16'd0, 16'd0, 16'd0};
        qb = '{16'd0, 16'd16384, 16'd0, 16'd0};
        send(pack(qa, qb, 15'd0));
        send(pack(qa, qb, 15'd16384));
        send(pack(qa, qb, 15'd8192));
        send(pack(qa, qb, 15'd20000));
        qb = '{-16'sd16384, 16'd0, 16'd0, 16'd0};
        send(pack(qa, qb, 15'd4096));
        qb = '{16'd16383, 16'd100, 16'd0, 16'd0};
        send(pack(qa, qb, 15'd8192));
        qb = '{-16'sd11585, 16'd11585, 16'd0, 16'd0};
        send(pack(qa, qb, 15'd12000));
        qa = '{16'd0, 16'd0, 16'd0, 16'd0};
        send(pack(qa, qb, 15'd8192));
        qa = '{16'd30000, 16'd30000, 16'd30000, 16'd30000};
        send(pack(qa, qa, 15'd5000));
        drain();

        for (int p = 0; p < 5; p++) begin
            write_threshold(settings[p]);
            if (p == 2) begin
                hold_off = 1;
                fork
                    repeat (400) @(posedge i_clk);
                    for (int i = 0; i < 150; i++) send(random_pair());
                join_any
                hold_off = 0;
                wait fork;
                for (int i = 0; i < 20; i++) send(random_pair());
            end else begin
                for (int i = 0; i < 170; i++) send(random_pair());
            end
            drain();
        end
        wait fork;

        if (errors == 0) begin
            $display("quaternion_slerp_interpolator test passed");
        end else begin
            $display("quaternion_slerp_interpolator test failed");
        end
        $finish;
    end
endmodule

// ----- quaternion_slerp_interpolator.f -----
rtl/core/qslerp_pkg.sv
rtl/core/qslerp_sqrt_cell.sv
rtl/core/qslerp_cordic_cell.sv
rtl/core/qslerp_div_cell.sv
rtl/core/quaternion_slerp_interpolator.sv
verif/quaternion_slerp_checker.sv
verif/quaternion_slerp_interpolator_tb.sv
